[rtl/fat12_pkg.sv]
// fat12_pkg: shared types, constants and command codes for the fat12 table engine
// no dependencies
package fat12_pkg;

  localparam int TableBytesDef = 512;
  localparam logic [11:0] BadMark = 12'hFF7;
  localparam logic [8:0] ClusterCountRst = 9'd339;
  localparam logic [11:0] EndMarkRst = 12'hFFF;

  typedef enum logic [2:0] {
    CMD_GET   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_ALLOC = 3'd2,
    CMD_FREE  = 3'd3,
    CMD_LOAD  = 3'd4,
    CMD_DUMP  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_COUNT = 2'd0,
    REG_END   = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_EVAL,
    S_WR0,
    S_WR1,
    S_BYTE,
    S_OUT
  } state_t;

endpackage

[rtl/fat12_if.sv]
// fat12_in_if / fat12_out_if: valid/ready channels carrying the engine payloads
// depends on nothing
interface fat12_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [11:0] cluster;
  logic [11:0] entry_value;
  logic [8:0]  byte_index;
  logic [7:0]  byte_in;
  modport source (output valid, cmd, cluster, entry_value, byte_index, byte_in, input ready);
  modport sink (input valid, cmd, cluster, entry_value, byte_index, byte_in, output ready);
endinterface

interface fat12_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] entry_out;
  logic [7:0]  byte_out;
  logic        dirty;
  logic [1:0]  status;
  modport source (output valid, entry_out, byte_out, dirty, status, input ready);
  modport sink (input valid, entry_out, byte_out, dirty, status, output ready);
endinterface

[rtl/fat12_mem.sv]
// fat12_mem: byte-wide table store, one write and one registered read port
// depends on fat12_pkg
module fat12_mem
  import fat12_pkg::*;
#(
  parameter int Depth = TableBytesDef,
  localparam int AW = $clog2(Depth)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/fat12_table_engine.sv]
// fat12_table_engine: one fat12 sector table with entry get/set, allocate, free chain, byte load/dump
// allocate scans entries upward from cluster 2 and free walks the chain entry by entry;
//   free rewrites each entry it visits, allocate writes only the free entry it finds;
//   both are bounded by cluster_count
// throughput: one command at a time, set by one byte read per cycle from the table memory
// reset: rst_n synchronous, clears control, dirty flag and configuration registers to defaults;
//   table contents are undefined until loaded
module fat12_table_engine
  import fat12_pkg::*;
#(
  parameter int TableBytes = TableBytesDef,
  localparam int AW = $clog2(TableBytes)
) (
  input  logic        clk,
  input  logic        rst_n,
  fat12_in_if.sink    in_ch,
  fat12_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [8:0]  cnt_r;
  logic [11:0] endm_r;
  reg_idx_t    ridx;
  assign ridx = cfg_paddr[2] ? REG_END : REG_COUNT;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= ClusterCountRst;
      endm_r <= EndMarkRst;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (ridx == REG_COUNT) cnt_r <= cfg_pwdata[8:0];
      else endm_r <= cfg_pwdata[11:0];
    end
  end

  always_comb begin
    case (ridx)
      REG_COUNT: cfg_prdata = {23'd0, cnt_r};
      default:   cfg_prdata = {20'd0, endm_r};
    endcase
  end

  // command state
  state_t      st_r, st_nxt;
  logic [2:0]  cmd_r;
  logic [11:0] clu_r, val_r, cnt12_r, eout_r;
  logic [8:0]  bidx_r;
  logic [7:0]  bin_r, lo_r, hi_r, bout_r;
  logic        dirty_r;
  logic [1:0]  stat_r;

  // byte offset of current cluster
  logic [13:0] off;
  logic        addr_ok;
  logic [11:0] entry;
  logic [7:0]  rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  wdata;
  logic [11:0] wval;
  logic        bidx_ok;

  assign off = 14'(({2'b00, clu_r} * 14'd3) >> 1);
  assign addr_ok = ({1'b0, clu_r} <= 13'(cnt_r) + 13'd1)
                 && (32'(off) + 32'd1 < 32'(TableBytes));
  assign bidx_ok = 32'(bidx_r) < 32'(TableBytes);
  // low byte held in lo_r, high byte arrives on rdata
  assign entry = clu_r[0] ? {rdata, lo_r[7:4]} : {rdata[3:0], lo_r};
  assign wval = (cmd_r == CMD_SET) ? val_r : (cmd_r == CMD_ALLOC) ? endm_r : 12'd0;

  fat12_mem #(.Depth(TableBytes)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.entry_out = eout_r;
  assign out_ch.byte_out = bout_r;
  assign out_ch.dirty = dirty_r;
  assign out_ch.status = stat_r;

  logic [11:0] next_r;

  always_comb begin
    st_nxt = st_r;
    we = 1'b0;
    waddr = AW'(off);
    wdata = 8'd0;
    raddr = AW'(off);
    case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = S_RD0;
      S_RD0: begin
        // dispatch; entry ops read the low byte
        raddr = AW'(off);
        case (cmd_r)
          CMD_GET, CMD_SET, CMD_ALLOC: st_nxt = addr_ok ? S_RD1 : S_OUT;
          CMD_FREE: begin
            if (clu_r < 12'd2 || clu_r >= BadMark) st_nxt = S_OUT;
            else if (!addr_ok || cnt12_r >= 12'(cnt_r)) st_nxt = S_OUT;
            else st_nxt = S_RD1;
          end
          CMD_LOAD, CMD_DUMP: begin
            raddr = AW'(bidx_r);
            st_nxt = S_BYTE;
          end
          default: st_nxt = S_OUT;
        endcase
      end
      S_RD1: begin
        raddr = AW'(off + 14'd1);
        st_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (cmd_r)
          CMD_GET: st_nxt = S_OUT;
          CMD_ALLOC: st_nxt = (entry == 12'd0) ? S_WR0 : S_RD0;
          default: st_nxt = S_WR0;
        endcase
      end
      S_WR0: begin
        we = 1'b1;
        waddr = AW'(off);
        wdata = clu_r[0] ? {wval[3:0], lo_r[3:0]} : wval[7:0];
        st_nxt = S_WR1;
      end
      S_WR1: begin
        we = 1'b1;
        waddr = AW'(off + 14'd1);
        wdata = clu_r[0] ? wval[11:4] : {hi_r[7:4], wval[11:8]};
        st_nxt = (cmd_r == CMD_FREE) ? S_RD0 : S_OUT;
      end
      S_BYTE: begin
        we = (cmd_r == CMD_LOAD) && bidx_ok;
        waddr = AW'(bidx_r);
        wdata = bin_r;
        st_nxt = S_OUT;
      end
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          cmd_r <= in_ch.cmd; val_r <= in_ch.entry_value;
          bidx_r <= in_ch.byte_index; bin_r <= in_ch.byte_in;
          clu_r <= (in_ch.cmd == CMD_ALLOC) ? 12'd2 : in_ch.cluster;
          cnt12_r <= 12'd0; eout_r <= 12'd0; bout_r <= 8'd0; stat_r <= ST_OK;
        end
        S_RD0: case (cmd_r)
          CMD_GET, CMD_SET: if (!addr_ok) stat_r <= ST_RANGE;
          CMD_ALLOC: if (!addr_ok) begin
            stat_r <= ST_FULL; eout_r <= 12'd0;
          end
          CMD_FREE: begin
            eout_r <= cnt12_r;
            if (!(clu_r < 12'd2 || clu_r >= BadMark) &&
                (!addr_ok || cnt12_r >= 12'(cnt_r))) stat_r <= ST_RANGE;
          end
          default: ;
        endcase
        S_RD1: lo_r <= rdata;
        S_EVAL: begin
          // old entry is the next link; keep the high byte for the even-entry merge
          next_r <= entry;
          hi_r <= rdata;
          if (cmd_r == CMD_GET) eout_r <= entry;
          if (cmd_r == CMD_ALLOC && entry != 12'd0) clu_r <= clu_r + 12'd1;
        end
        S_WR1: begin
          dirty_r <= 1'b1;
          if (cmd_r == CMD_ALLOC) eout_r <= clu_r;
          if (cmd_r == CMD_FREE) begin
            cnt12_r <= cnt12_r + 12'd1;
            eout_r <= cnt12_r + 12'd1;
            clu_r <= next_r;
          end
        end
        S_BYTE: begin
          if (!bidx_ok) stat_r <= ST_RANGE;
          else if (cmd_r == CMD_LOAD) dirty_r <= 1'b0;
          else begin
            bout_r <= rdata;
            if (32'(bidx_r) == 32'(TableBytes - 1)) dirty_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped");
  a_wr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WR0 |=> st_r == S_WR1) else $error("split entry write");
`endif
endmodule
